[src/swv_pkg.sv]
// ----------------------------------------------------------------------------
// swv_pkg: shared types and constants of the sliding window variance core
// Widths of the fixed fields, register indexes, reset values and the command
// word of the shared shift/add unit.
// ----------------------------------------------------------------------------
package swv_pkg;

   // fixed field widths
   localparam int AXES       = 6;
   localparam int VAR_W      = 40;
   localparam int FRAC_W     = 8;
   localparam int QUOT_SHIFT = VAR_W - FRAC_W;
   localparam int CSR_CNT_W  = 11;
   localparam int CSR_INT_W  = 16;
   localparam int CSR_DATA_W = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int AXIS_IDX_W = 3;

   // parameter defaults
   localparam int DEF_WINDOW_DEPTH = 1024;
   localparam int DEF_SAMPLE_BITS  = 16;

   // register reset values
   localparam logic [CSR_CNT_W-1:0] RST_WIN_LEN         = 11'd1024;
   localparam logic [CSR_CNT_W-1:0] RST_FILL_NEED       = 11'd100;
   localparam logic [VAR_W-1:0]     RST_VAR_FLOOR       = 40'd256;
   localparam logic [CSR_INT_W-1:0] RST_UPDATE_INTERVAL = 16'd50;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_WIN_LEN         = 2'd0,
      REG_FILL_NEED       = 2'd1,
      REG_VAR_FLOOR       = 2'd2,
      REG_UPDATE_INTERVAL = 2'd3
   } csr_reg_type;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   // operations of the shared unit
   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

[src/sliding_window_variance_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_variance_core: windowed sample variance of six IMU axes
// Stationary samples enter a ring window; per-axis sums and sums of squares
// follow it, and every update_interval samples the unbiased variances are
// recomputed on one shared shift/add unit.
//
//  channel | ports          | payload (low bit first)
//  --------+----------------+------------------------------------------------
//  input   | req_t*         | tdata: accel_x/y/z, gyro_x/y/z; tuser: req_type,
//          |                |        stationary
//  result  | rsp_t*         | tdata: 6 variances, fill_count; tuser: ready_res,
//          |                |        updated
//  config  | csr_*          | win_len, fill_need, var_floor,
//          |                | update_interval
//
// A clear or a non-stationary word skips the sample squarer; a stationary
// sample passes every axis through it, first for the old values, then the new.
// A word that recomputes adds n*(n-1) and, per axis, n*S2, S1^2 (one bit a
// cycle) and a 40-step division. One word is in work at a time; its result
// waits in the output register while the next word is taken. No clearing
// pass after reset.
// ----------------------------------------------------------------------------
module sliding_window_variance_core #(
   parameter int WINDOW_DEPTH = swv_pkg::DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = swv_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, zero fill
   input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   // req_type, stationary
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // accel_var_x..gyro_var_z, fill_count, zero fill
   output logic [((6*swv_pkg::VAR_W+$clog2(WINDOW_DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   // ready_res, updated
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [swv_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [swv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import swv_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int AW   = $clog2(WINDOW_DEPTH);
   localparam int NW   = $clog2(WINDOW_DEPTH + 1);
   localparam int SW   = SB + NW;
   localparam int QW   = 2*SB + NW - 2;
   localparam int UW   = NW + QW;
   localparam int CW   = ((NW > CSR_CNT_W) ? NW : CSR_CNT_W) + 1;
   localparam int MEMW = AXES * SB;
   localparam int RQW  = ((6*SB+7)/8)*8;
   localparam int RSW  = ((6*VAR_W+NW+7)/8)*8;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LOAD = 8'b0000_0010,
      ST_POST = 8'b0000_0100,
      ST_MM   = 8'b0000_1000,
      ST_NS2  = 8'b0001_0000,
      ST_S1SQ = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [CSR_CNT_W-1:0]     win_len_ff, fill_need_ff;
   logic [VAR_W-1:0]         min_var_ff;
   logic [CSR_INT_W-1:0]     interval_ff;

   logic [AW-1:0]            wp_ff, wp_in;
   logic [NW-1:0]            count_ff, count_in;
   logic [CSR_INT_W-1:0]     since_ff, since_in;
   logic signed [SW-1:0]     s1_ff [AXES];
   logic signed [SW-1:0]     s1_in [AXES];
   logic [QW-1:0]            s2_ff [AXES];
   logic [QW-1:0]            s2_in [AXES];
   logic [VAR_W-1:0]         var_ff [AXES];
   logic [VAR_W-1:0]         var_in [AXES];

   logic signed [SB-1:0]     smp_ff [AXES];
   logic signed [SB-1:0]     smp_in [AXES];
   logic                     drop_ff, drop_in;
   logic [AXIS_IDX_W-1:0]    ax_ff, ax_in;
   logic                     new_ff, new_in;
   logic                     ph_ff, ph_in;
   logic [2*SB-1:0]          sq_ff;
   logic [UW-1:0]            m_ff, m_in;
   logic [UW-1:0]            ns2_ff, ns2_in;
   logic [UW-1:0]            d_ff, d_in;
   logic                     start_ff, start_in;
   logic                     updated_ff, updated_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSW-1:0]           rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   logic                     req_fire;
   logic [CW-1:0]            eff;
   logic                     drop_now;
   logic [NW:0]              old_sum;
   logic [AW-1:0]            old_addr;
   logic [MEMW-1:0]          rd_data;
   logic [MEMW-1:0]          wr_data;
   logic                     mem_we;
   logic signed [SB-1:0]     x_sel;
   logic signed [2*SB-1:0]   sq_prod;
   logic                     apply;
   logic [NW-1:0]            count_nx;
   logic [CSR_INT_W-1:0]     since_nx;
   logic                     upd_due;
   logic                     ready_now;
   logic [SW-1:0]            s1_abs;

   alu_cmd_type              alu_cmd;
   logic [UW-1:0]            alu_a, alu_b;
   logic                     alu_done;
   logic [UW-1:0]            alu_prod;
   logic [VAR_W-1:0]         alu_quot;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // clamp the window size to 1..WINDOW_DEPTH
   always_comb begin
      if (win_len_ff == '0) begin
         eff = CW'(1);
      end else if (CW'(win_len_ff) > DEPTH_C) begin
         eff = DEPTH_C;
      end else begin
         eff = CW'(win_len_ff);
      end
   end

   // oldest entry of the window
   assign drop_now = (CW'(count_ff) + CW'(1)) > eff;
   assign old_sum  = ((NW+1)'(wp_ff) >= (NW+1)'(count_ff))
                   ? (NW+1)'(wp_ff) - (NW+1)'(count_ff)
                   : (NW+1)'(wp_ff) + (NW+1)'(WINDOW_DEPTH) - (NW+1)'(count_ff);
   assign old_addr = old_sum[AW-1:0];

   // pack the new sample for the store
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         wr_data[i*SB +: SB] = smp_ff[i];
      end
   end

   assign mem_we = (state_ff == ST_POST);

   swv_window_mem #(
      .DEPTH (WINDOW_DEPTH),
      .DW    (MEMW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (old_addr),
      .rd_data (rd_data)
   );

   // sample squarer, its product registered for the apply phase
   assign x_sel   = new_ff ? smp_ff[ax_ff] : $signed(rd_data[ax_ff*SB +: SB]);
   assign sq_prod = x_sel * x_sel;
   assign apply   = new_ff || drop_ff;

   always_ff @(posedge clock) begin
      sq_ff <= sq_prod;
   end

   // bookkeeping after the sums are settled
   assign count_nx  = drop_ff ? count_ff : count_ff + NW'(1);
   assign since_nx  = (since_ff < interval_ff) ? since_ff + CSR_INT_W'(1) : since_ff;
   assign upd_due   = (since_nx >= interval_ff)
                   && (CW'(count_nx) >= CW'(fill_need_ff));
   assign ready_now = CW'(count_ff) >= CW'(fill_need_ff);
   assign s1_abs    = s1_ff[ax_ff][SW-1] ? SW'(-s1_ff[ax_ff]) : SW'(s1_ff[ax_ff]);

   // operands of the shared unit
   always_comb begin
      alu_cmd.start = start_ff;
      alu_cmd.op    = ALU_MUL;
      alu_a         = '0;
      alu_b         = '0;
      unique case (1'b1)
         (state_ff == ST_MM): begin
            alu_a = UW'(count_ff);
            alu_b = UW'(count_ff - NW'(1));
         end
         (state_ff == ST_NS2): begin
            alu_a = UW'(s2_ff[ax_ff]);
            alu_b = UW'(count_ff);
         end
         (state_ff == ST_S1SQ): begin
            alu_a = UW'(s1_abs);
            alu_b = UW'(s1_abs);
         end
         (state_ff == ST_DIV): begin
            alu_cmd.op = ALU_DIV;
            alu_a      = d_ff;
            alu_b      = m_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   swv_alu #(
      .UW (UW)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (alu_a),
      .opb   (alu_b),
      .done  (alu_done),
      .prod  (alu_prod),
      .quot  (alu_quot)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      since_in     = since_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      var_in       = var_ff;
      smp_in       = smp_ff;
      drop_in      = drop_ff;
      ax_in        = ax_ff;
      new_in       = new_ff;
      ph_in        = ph_ff;
      m_in         = m_ff;
      ns2_in       = ns2_ff;
      d_in         = d_ff;
      start_in     = 1'b0;
      updated_in   = updated_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               updated_in = 1'b0;
               for (int i = 0; i < AXES; i++) begin
                  smp_in[i] = $signed(req_tdata[i*SB +: SB]);
               end
               drop_in = drop_now;
               ax_in   = '0;
               new_in  = 1'b0;
               ph_in   = 1'b0;
               if (req_tuser[0] == REQ_CLEAR) begin
                  wp_in    = '0;
                  count_in = '0;
                  since_in = '0;
                  for (int i = 0; i < AXES; i++) begin
                     s1_in[i]  = '0;
                     s2_in[i]  = '0;
                     var_in[i] = '0;
                  end
                  state_in = ST_DONE;
               end else if (req_tuser[1]) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOAD: begin
            // square in phase 0, retire old or add new in phase 1
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (apply) begin
                  if (new_ff) begin
                     s1_in[ax_ff] = s1_ff[ax_ff] + SW'(x_sel);
                     s2_in[ax_ff] = s2_ff[ax_ff] + QW'(sq_ff);
                  end else begin
                     s1_in[ax_ff] = s1_ff[ax_ff] - SW'(x_sel);
                     s2_in[ax_ff] = s2_ff[ax_ff] - QW'(sq_ff);
                  end
               end
               if (ax_ff == AXIS_IDX_W'(AXES-1)) begin
                  ax_in = '0;
                  if (new_ff) begin
                     state_in = ST_POST;
                  end else begin
                     new_in = 1'b1;
                  end
               end else begin
                  ax_in = ax_ff + AXIS_IDX_W'(1);
               end
            end
         end
         ST_POST: begin
            wp_in    = (wp_ff == AW'(WINDOW_DEPTH-1)) ? '0 : wp_ff + AW'(1);
            count_in = count_nx;
            since_in = since_nx;
            ax_in    = '0;
            if (upd_due) begin
               since_in = '0;
            end
            if (upd_due && (count_nx >= NW'(2))) begin
               updated_in = 1'b1;
               start_in   = 1'b1;
               state_in   = ST_MM;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MM: begin
            if (alu_done) begin
               m_in     = alu_prod;
               start_in = 1'b1;
               state_in = ST_NS2;
            end
         end
         ST_NS2: begin
            if (alu_done) begin
               ns2_in   = alu_prod;
               start_in = 1'b1;
               state_in = ST_S1SQ;
            end
         end
         ST_S1SQ: begin
            if (alu_done) begin
               d_in     = ns2_ff - alu_prod;
               start_in = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (alu_done) begin
               var_in[ax_ff] = (alu_quot < min_var_ff) ? min_var_ff : alu_quot;
               if (ax_ff == AXIS_IDX_W'(AXES-1)) begin
                  state_in = ST_DONE;
               end else begin
                  ax_in    = ax_ff + AXIS_IDX_W'(1);
                  start_in = 1'b1;
                  state_in = ST_NS2;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < AXES; i++) begin
                  rsp_data_in[i*VAR_W +: VAR_W] = var_ff[i];
               end
               rsp_data_in[AXES*VAR_W +: NW]            = count_ff;
               rsp_data_in[RSW-1:AXES*VAR_W+NW]         = '0;
               rsp_user_in  = {updated_ff, ready_now};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_len_ff   <= RST_WIN_LEN;
         fill_need_ff <= RST_FILL_NEED;
         min_var_ff   <= RST_VAR_FLOOR;
         interval_ff  <= RST_UPDATE_INTERVAL;
         wp_ff        <= '0;
         count_ff     <= '0;
         since_ff     <= '0;
         start_ff     <= 1'b0;
         updated_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            s1_ff[i]  <= '0;
            s2_ff[i]  <= '0;
            var_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         since_ff     <= since_in;
         start_ff     <= start_in;
         updated_ff   <= updated_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         var_ff       <= var_in;
         if (csr_we) begin
            unique case (csr_reg_type'(csr_addr))
               REG_WIN_LEN:         win_len_ff   <= csr_wdata[CSR_CNT_W-1:0];
               REG_FILL_NEED:       fill_need_ff <= csr_wdata[CSR_CNT_W-1:0];
               REG_VAR_FLOOR:       min_var_ff   <= csr_wdata[VAR_W-1:0];
               REG_UPDATE_INTERVAL: interval_ff  <= csr_wdata[CSR_INT_W-1:0];
            endcase
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      drop_ff     <= drop_in;
      ax_ff       <= ax_in;
      new_ff      <= new_in;
      ph_ff       <= ph_in;
      m_ff        <= m_in;
      ns2_ff      <= ns2_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a clear empties the window at once
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser[0] == REQ_CLEAR) |=> (count_ff == '0) && (wp_ff == '0))
      else $error("clear did not empty the window");

   // a recomputed result always reports a filled window
   a_updated_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("update reported without enough samples");

   // the shared unit finishes only inside a recompute step
   a_alu_in_recompute: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == ST_MM) || (state_ff == ST_NS2)
                || (state_ff == ST_S1SQ) || (state_ff == ST_DIV))
      else $error("shared unit finished outside a recompute step");

   // fill never passes the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POST |=> CW'(count_ff) <= DEPTH_C)
      else $error("fill count beyond store depth");

endmodule

[src/swv_alu.sv]
// ----------------------------------------------------------------------------
// swv_alu: shared shift/add unit
// One adder/subtractor stepped under a counter. MUL: shift-add product, one
// multiplier bit a cycle, stops when the multiplier runs out of ones.
// DIV: restoring division giving floor(256*a/b), one quotient bit a cycle,
// saturated to all ones when the quotient does not fit in VAR_W bits.
// ----------------------------------------------------------------------------
module swv_alu #(
   parameter int UW = 52
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swv_pkg::alu_cmd_type      cmd,
   input  logic [UW-1:0]             opa,
   input  logic [UW-1:0]             opb,
   output logic                      done,
   output logic [UW-1:0]             prod,
   output logic [swv_pkg::VAR_W-1:0] quot
);
   import swv_pkg::*;

   localparam int MW  = (UW > VAR_W) ? UW : VAR_W;
   localparam int EW  = ((UW > QUOT_SHIFT) ? UW : QUOT_SHIFT) + 1;
   localparam int SCW = $clog2(VAR_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   alu_op_type       op_ff, op_in;
   logic [UW-1:0]    acc_ff, acc_in;
   logic [MW-1:0]    mcand_ff, mcand_in;
   logic [UW-1:0]    mplr_ff, mplr_in;
   logic [SCW-1:0]   cnt_ff, cnt_in;

   logic [EW-1:0]    dx;
   logic [EW-1:0]    dx_hi;
   logic             ovf;
   logic [UW-1:0]    rem_sh;
   logic [UW-1:0]    add_a;
   logic [UW-1:0]    add_b;
   logic [UW:0]      sum;

   // overflow check: quotient fits only if a < b * 2^QUOT_SHIFT
   assign dx    = EW'(opa);
   assign dx_hi = dx >> QUOT_SHIFT;
   assign ovf   = dx_hi >= EW'(opb);

   // single adder, subtracting in DIV mode
   assign rem_sh = {acc_ff[UW-2:0], mcand_ff[VAR_W-1]};
   assign add_a  = (op_ff == ALU_DIV) ? rem_sh : acc_ff;
   assign add_b  = (op_ff == ALU_DIV) ? ~mplr_ff
                 : (mplr_ff[0] ? mcand_ff[UW-1:0] : '0);
   assign sum    = {1'b0, add_a} + {1'b0, add_b} + (UW+1)'(op_ff == ALU_DIV);

   // step control
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      cnt_in   = cnt_ff;
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         mplr_in = opb;
         if (cmd.op == ALU_MUL) begin
            acc_in   = '0;
            mcand_in = MW'(opa);
         end else if (ovf) begin
            mcand_in = '1;
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end else begin
            acc_in   = UW'(dx_hi);
            mcand_in = MW'({dx[QUOT_SHIFT-1:0], {FRAC_W{1'b0}}});
            cnt_in   = SCW'(VAR_W);
         end
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            if (mplr_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               acc_in   = sum[UW-1:0];
               mcand_in = {mcand_ff[MW-2:0], 1'b0};
               mplr_in  = {1'b0, mplr_ff[UW-1:1]};
            end
         end else begin
            acc_in   = sum[UW] ? sum[UW-1:0] : rem_sh;
            mcand_in = {mcand_ff[MW-2:0], sum[UW]};
            cnt_in   = cnt_ff - SCW'(1);
            if (cnt_ff == SCW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      cnt_ff   <= cnt_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
   assign quot = mcand_ff[VAR_W-1:0];

endmodule

[src/swv_window_mem.sv]
// ----------------------------------------------------------------------------
// swv_window_mem: sample ring storage
// One write port and one read port, read data registered. Entries are
// undefined until written.
// ----------------------------------------------------------------------------
module swv_window_mem #(
   parameter int DEPTH = 1024,
   parameter int DW    = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the sliding window variance core
// Drives IMU words on the request stream with random gaps, predicts each
// result word from an in-bench window model and compares it field by field
// with the response stream, which is stalled at random. Register settings
// change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;
   import swv_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int REQ_W     = 96;
   localparam int RSP_W     = 256;
   localparam int WATCH_MAX = 40000;
   localparam int EXP_DEPTH = 64;
   localparam logic [39:0] VAR_MAX = 40'hFF_FFFF_FFFF;

   typedef struct {
      logic               kind;
      logic               still;
      logic signed [15:0] axis [AXES];
   } imu_word_type;

   typedef struct {
      logic [39:0] var_val [AXES];
      logic        ready_res;
      logic [10:0] fill;
      logic        updated;
   } var_word_type;

   logic clock;
   logic reset = 1'b1;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   sliding_window_variance_core DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predicted registers and window state
   logic [10:0]        win_len;
   logic [10:0]        fill_need;
   logic [39:0]        var_floor;
   logic [15:0]        upd_every;
   logic signed [15:0] ring [DEPTH][AXES];
   int unsigned        wr_ptr;
   int unsigned        held;
   int unsigned        since_upd;
   longint             sum1 [AXES];
   bit [63:0]          sum2 [AXES];
   logic [39:0]        cur_var [AXES];

   // predicted result words in flight, oldest at exp_rd
   var_word_type exp_slot [EXP_DEPTH];
   int  exp_wr = 0;
   int  exp_rd = 0;
   int  errors = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random gap length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   function automatic logic [39:0] axis_var_of(int ax, bit [63:0] n);
      bit [63:0] mag, d, m, q, r, v;
      mag = (sum1[ax] < 0) ? 64'(-sum1[ax]) : 64'(sum1[ax]);
      d = n * sum2[ax] - mag * mag;
      m = n * (n - 1);
      q = d / m;
      r = d % m;
      if (q > (64'(VAR_MAX) >> 8)) v = 64'(VAR_MAX);
      else v = (q << 8) + ((r << 8) / m);
      if (v > 64'(VAR_MAX)) v = 64'(VAR_MAX);
      return (v < 64'(var_floor)) ? var_floor : v[39:0];
   endfunction

   // advance the window state by one word and return the result it gives
   function automatic var_word_type predict_vars(imu_word_type w);
      var_word_type res;
      int unsigned eff, old;
      longint o;
      res.updated = 1'b0;
      if (w.kind == REQ_CLEAR) begin
         wr_ptr = 0; held = 0; since_upd = 0;
         for (int a = 0; a < AXES; a++) begin
            sum1[a] = 0; sum2[a] = 0; cur_var[a] = '0;
         end
      end else if (w.still) begin
         eff = win_len;
         if (eff < 1) eff = 1;
         if (eff > DEPTH) eff = DEPTH;
         if (held + 1 > eff) begin
            old = (wr_ptr >= held) ? wr_ptr - held : wr_ptr + DEPTH - held;
            if (old >= DEPTH) old = 0;
            for (int a = 0; a < AXES; a++) begin
               o = ring[old][a];
               sum1[a] -= o;
               sum2[a] -= 64'(o * o);
            end
         end else begin
            held++;
         end
         for (int a = 0; a < AXES; a++) begin
            o = w.axis[a];
            ring[wr_ptr][a] = w.axis[a];
            sum1[a] += o;
            sum2[a] += 64'(o * o);
         end
         wr_ptr = (wr_ptr + 1) % DEPTH;
         if (since_upd < upd_every) since_upd++;
         if (since_upd >= upd_every && held >= fill_need) begin
            since_upd = 0;
            if (held >= 2) begin
               for (int a = 0; a < AXES; a++) cur_var[a] = axis_var_of(a, held);
               res.updated = 1'b1;
            end
         end
      end
      for (int a = 0; a < AXES; a++) res.var_val[a] = cur_var[a];
      res.ready_res = (held >= fill_need);
      res.fill      = held[10:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // send one word, then record what it must produce
   task automatic send_word(imu_word_type w);
      int gap;
      logic [REQ_W-1:0] data;
      gap = pick_gap();
      data = '0;
      for (int a = 0; a < AXES; a++) data[16*a +: 16] = w.axis[a];
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= {w.still, w.kind};
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      exp_slot[exp_wr % EXP_DEPTH] = predict_vars(w);
      exp_wr++;
   endtask

   // hold off the sender until every result is back
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(csr_reg_type idx, logic [39:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
      case (idx)
         REG_WIN_LEN:         win_len   = value[10:0];
         REG_FILL_NEED:       fill_need = value[10:0];
         REG_VAR_FLOOR:       var_floor = value;
         REG_UPDATE_INTERVAL: upd_every = value[15:0];
      endcase
   endtask

   task automatic configure(logic [39:0] ws, logic [39:0] ms, logic [39:0] mv,
                            logic [39:0] ui);
      csr_write(REG_WIN_LEN, ws);
      csr_write(REG_FILL_NEED, ms);
      csr_write(REG_VAR_FLOOR, mv);
      csr_write(REG_UPDATE_INTERVAL, ui);
   endtask

   function automatic imu_word_type flat_word(logic kind, logic still,
                                              logic signed [15:0] v);
      imu_word_type w;
      w.kind = kind; w.still = still;
      for (int a = 0; a < AXES; a++) w.axis[a] = v;
      return w;
   endfunction

   function automatic imu_word_type random_word(int clear_pct, int moving_pct);
      imu_word_type w;
      int r, mode;
      logic signed [15:0] bias;
      r = $urandom_range(99);
      w.kind  = (r < clear_pct) ? REQ_CLEAR : REQ_SAMPLE;
      w.still = (r >= clear_pct + moving_pct) ? 1'b1 : 1'($urandom_range(1));
      mode = $urandom_range(9);
      bias = 16'($urandom);
      for (int a = 0; a < AXES; a++) begin
         case (mode)
            0:       w.axis[a] = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: w.axis[a] = 16'($urandom);
            default: w.axis[a] = bias + 16'($signed($urandom_range(64)) - 32);
         endcase
      end
      return w;
   endfunction

   // reset defaults, a few words
   task automatic test_defaults();
      for (int i = 0; i < 5; i++) send_word(random_word(0, 20));
      drain();
   endtask

   task automatic test_directed();
      imu_word_type w;
      configure(4, 2, 0, 1);
      send_word(flat_word(REQ_CLEAR, 1'b0, 0));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh7FFF));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh8000));
      // moving word: state held, no update
      send_word(flat_word(REQ_SAMPLE, 1'b0, 16'sh1234));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 0));
      w = flat_word(REQ_SAMPLE, 1'b1, -1);
      w.axis[1] = 16'sh7FFF; w.axis[4] = 16'sh8000;
      send_word(w);
      // window full: oldest drops out
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh8000));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh7FFF));
      send_word(flat_word(REQ_CLEAR, 1'b1, 16'sh7FFF));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 5));
      drain();
      // floor at its top
      csr_write(REG_VAR_FLOOR, VAR_MAX);
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh8000));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh7FFF));
      drain();
      // zero threshold and interval; fill below two keeps the variances
      configure(3, 0, 300, 0);
      send_word(flat_word(REQ_CLEAR, 1'b0, 0));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 100));
      send_word(flat_word(REQ_SAMPLE, 1'b1, -100));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 7));
      drain();
      // window of zero acts as one
      csr_write(REG_WIN_LEN, 0);
      send_word(flat_word(REQ_CLEAR, 1'b0, 0));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh7FFF));
      send_word(flat_word(REQ_SAMPLE, 1'b1, 16'sh8000));
      drain();
   endtask

   // shrink the window below the fill: the fill must stay
   task automatic test_window_shrink();
      configure(16, 2, 0, 3);
      send_word(flat_word(REQ_CLEAR, 1'b0, 0));
      repeat (10) send_word(random_word(0, 0));
      drain();
      csr_write(REG_WIN_LEN, 3);
      repeat (12) send_word(random_word(0, 0));
      drain();
   endtask

   task automatic run_phase(logic [39:0] ws, logic [39:0] ms, logic [39:0] mv,
                            logic [39:0] ui, int count);
      configure(ws, ms, mv, ui);
      quiet = ($urandom_range(3) == 0);
      for (int i = 0; i < count; i++) send_word(random_word(1, 5));
      drain();
   endtask

   task automatic test_random();
      run_phase(1024, 100, 256, 50, 400);
      run_phase(2, 1, 0, 1, 100);
      run_phase(64, 32, 40'd1000, 8, 300);
      run_phase(2047, 0, 0, 0, 80);
      run_phase(300, 1024, 256, 65535, 200);
      run_phase(17, 5, VAR_MAX, 3, 150);
      run_phase(1000, 600, 40'd12, 20, 300);
   endtask

   // result stall pattern: runs of ready and runs of stall
   initial begin
      int len;
      forever begin
         len = $urandom_range(30, 1);
         repeat (len) @(negedge clock) rsp_tready <= 1'b1;
         len = pick_gap();
         if (len > 0) repeat (len) @(negedge clock) rsp_tready <= 1'b0;
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      var_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_rd == exp_wr) begin
            report_mismatch("unexpected result word", 1, 0);
         end else begin
            e = exp_slot[exp_rd % EXP_DEPTH];
            exp_rd++;
            for (int a = 0; a < AXES; a++)
               if (rsp_tdata[40*a +: 40] !== e.var_val[a])
                  report_mismatch($sformatf("variance axis %0d", a),
                                  rsp_tdata[40*a +: 40], e.var_val[a]);
            if (rsp_tdata[240 +: 11] !== e.fill)
               report_mismatch("fill_count", rsp_tdata[240 +: 11], e.fill);
            if (rsp_tuser[0] !== e.ready_res)
               report_mismatch("ready_res", rsp_tuser[0], e.ready_res);
            if (rsp_tuser[1] !== e.updated)
               report_mismatch("updated", rsp_tuser[1], e.updated);
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCH_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      win_len = RST_WIN_LEN;
      fill_need = RST_FILL_NEED;
      var_floor = RST_VAR_FLOOR;
      upd_every = RST_UPDATE_INTERVAL;
      wr_ptr = 0; held = 0; since_upd = 0;
      for (int a = 0; a < AXES; a++) begin
         sum1[a] = 0; sum2[a] = 0; cur_var[a] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_defaults();
      test_directed();
      test_window_shrink();
      test_random();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
